>>> hw/rtl/sorted_value_list_macros.svh
// ----------------------------------------------------------------------------
// Sorted value list assertion macros
// Shared concurrent assertion forms used by the sorted value list RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_VALUE_LIST_MACROS_SVH
`define SORTED_VALUE_LIST_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SVL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sorted value list: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SVL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sorted value list: assertion failed");

`endif

>>> hw/rtl/svl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted value list package
// Field widths, operation and status codes, and the cell command bundle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package svl_pkg;

	localparam int ValueW  = 8;
	localparam int StatusW = 2;
	localparam int CountW  = 5;

	// Operation codes carried in the func field.
	typedef enum logic {
		FN_INSERT = 1'b0,
		FN_DELETE = 1'b1
	} func_t;

	// Result status codes.
	typedef enum logic [StatusW-1:0] {
		ST_INSERTED  = 2'd0,
		ST_FULL      = 2'd1,
		ST_DELETED   = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	// Command broadcast to every cell of the row.
	typedef struct packed {
		logic [ValueW-1:0] value;
		logic              insert_en;
		logic              delete_en;
	} cell_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/svl_in_if.sv
// ----------------------------------------------------------------------------
// Sorted value list input channel
// Valid/ready channel that carries one list operation per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface svl_in_if;
	import svl_pkg::*;

	logic              valid;
	logic              ready;
	logic              func;
	logic [ValueW-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink   (input valid, input func, input value, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/svl_out_if.sv
// ----------------------------------------------------------------------------
// Sorted value list output channel
// Valid/ready channel that carries one operation result per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface svl_out_if;
	import svl_pkg::*;

	logic               valid;
	logic               ready;
	logic [StatusW-1:0] status;
	logic [CountW-1:0]  entry_count;
	logic [ValueW-1:0]  smallest_value;

	modport source (output valid, output status, output entry_count, output smallest_value,
		input ready);
	modport sink   (input valid, input status, input entry_count, input smallest_value,
		output ready);
endinterface

`default_nettype wire

>>> hw/rtl/svl_cell.sv
// ----------------------------------------------------------------------------
// Sorted value list cell
// Holds one list entry and shifts it with its neighbours on insert or delete.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module svl_cell (
	input  wire logic                     clk,
	input  wire svl_pkg::cell_cmd_t       cmd,
	input  wire logic                     occ,
	input  wire logic                     left_lt,
	input  wire logic [svl_pkg::ValueW-1:0] left_entry,
	input  wire logic [svl_pkg::ValueW-1:0] right_entry,
	output logic [svl_pkg::ValueW-1:0]    entry,
	output logic                          lt,
	output logic                          eq
);
	import svl_pkg::*;

	logic [ValueW-1:0] entry_q;

	// Compare the stored entry against the operand; the list is ascending, so
	// the cells that hold a smaller value form an unbroken run from the head.
	assign lt    = occ && (entry_q < cmd.value);
	assign eq    = occ && (entry_q == cmd.value);
	assign entry = entry_q;

	// An insert keeps smaller entries, drops the operand into the first cell
	// that is not smaller and moves the rest one place towards the tail. A
	// delete pulls every entry from the first equal one onwards one place back.
	always_ff @(posedge clk) begin
		if (cmd.insert_en && !lt) begin
			entry_q <= left_lt ? cmd.value : left_entry;
		end else if (cmd.delete_en && !lt) begin
			entry_q <= right_entry;
		end
	end
endmodule

`default_nettype wire

>>> hw/rtl/sorted_value_list.sv
// ----------------------------------------------------------------------------
// Sorted value list
// Ascending list of 8-bit values held in a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  in_ch    sink       func (insert or delete), value
//  out_ch   source     status, entry_count, smallest_value
//
//  One item is processed per clock: every cell compares its entry with the
//  operand in parallel and the row shifts in the same edge that accepts it.
//  The result sits in an output register; a new item is taken while that
//  register is empty or is being read, so a stalled output stops the input.
//  Reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "sorted_value_list_macros.svh"

module sorted_value_list #(
	parameter int CAPACITY = 16
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	svl_in_if.sink     in_ch,
	svl_out_if.source  out_ch
);
	import svl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_d;
	logic [CW+CountW-1:0] count_ext;
	logic [ValueW-1:0]   entry [CAPACITY];
	logic [CAPACITY-1:0] lt;
	logic [CAPACITY-1:0] eq;
	logic [CAPACITY-1:0] occ;
	cell_cmd_t           cmd;
	logic                accept;
	logic                is_insert;
	logic                full;
	logic                found;
	logic                out_valid_q;
	status_t             status_d;
	status_t             status_q;
	logic [CountW-1:0]   entry_count_q;
	logic [ValueW-1:0]   smallest_d;
	logic [ValueW-1:0]   smallest_q;

	// Handshake: take an item whenever the result register is empty or is being read.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	// Operation decode and list-wide flags.
	assign is_insert     = (in_ch.func == FN_INSERT);
	assign full          = (count_q == CW'(CAPACITY));
	assign found         = |eq;
	assign cmd.value     = in_ch.value;
	assign cmd.insert_en = accept && is_insert && !full;
	assign cmd.delete_en = accept && !is_insert && found;

	// Row of cells, each linked to its neighbours.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic              left_lt;
		logic [ValueW-1:0] left_entry;
		logic [ValueW-1:0] right_entry;

		assign occ[i] = (CW'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_lt    = 1'b1;
			assign left_entry = in_ch.value;
		end else begin : g_body
			assign left_lt    = lt[i-1];
			assign left_entry = entry[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_entry = entry[i];
		end else begin : g_inner
			assign right_entry = entry[i+1];
		end

		svl_cell u_cell (
			.clk         (clk),
			.cmd         (cmd),
			.occ         (occ[i]),
			.left_lt     (left_lt),
			.left_entry  (left_entry),
			.right_entry (right_entry),
			.entry       (entry[i]),
			.lt          (lt[i]),
			.eq          (eq[i])
		);
	end

	// Entry count after the operation.
	always_comb begin
		count_d = count_q;
		if (cmd.insert_en) begin
			count_d = count_q + 1'b1;
		end else if (cmd.delete_en) begin
			count_d = count_q - 1'b1;
		end
	end

	assign count_ext = {{CountW{1'b0}}, count_d};

	// Status and head of the list after the operation.
	always_comb begin
		if (is_insert) begin
			status_d   = full ? ST_FULL : ST_INSERTED;
			smallest_d = (full || lt[0]) ? entry[0] : in_ch.value;
		end else if (found) begin
			status_d = ST_DELETED;
			if (count_d == '0) begin
				smallest_d = '0;
			end else if (eq[0]) begin
				smallest_d = entry[1];
			end else begin
				smallest_d = entry[0];
			end
		end else begin
			status_d   = ST_NOT_FOUND;
			smallest_d = (count_q == '0) ? '0 : entry[0];
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q      <= status_d;
			entry_count_q <= count_ext[CountW-1:0];
			smallest_q    <= smallest_d;
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.status         = status_q;
	assign out_ch.entry_count    = entry_count_q;
	assign out_ch.smallest_value = smallest_q;

	// Checks on the list state and the result register.
	`SVL_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(CAPACITY))
	`SVL_ASSERT_NEXT(a_insert_grows, clk, arst_n, cmd.insert_en, count_q == $past(count_q) + 1'b1)
	`SVL_ASSERT_NEXT(a_result_held, clk, arst_n, accept, out_valid_q)
	`SVL_ASSERT_SAME(a_head_order, clk, arst_n, count_q >= CW'(2), entry[0] <= entry[1])

endmodule

`default_nettype wire

>>> test/sorted_value_list_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted value list testbench
// Drives insert and delete items into the sorted list, predicts each result
// from a behavioural copy of the list, and compares every returned result
// field by field. Both channels idle and stall at random between items.
// ----------------------------------------------------------------------------

module sorted_value_list_tb;
	import svl_pkg::*;

	localparam int LIST_DEPTH  = 16;
	localparam int RANDOM_OPS  = 950;
	localparam int CYCLE_LIMIT = 200000;

	// One list operation as carried on the input channel.
	typedef struct packed {
		func_t             fn;
		logic [ValueW-1:0] value;
	} list_op_t;

	// One result as carried on the output channel.
	typedef struct packed {
		status_t           status;
		logic [CountW-1:0] entry_count;
		logic [ValueW-1:0] smallest_value;
	} list_result_t;

	// Behavioural copy of the list contents.
	typedef struct {
		logic [ValueW-1:0] entry [LIST_DEPTH];
		int unsigned       count;
	} list_state_t;

	logic clk;
	logic arst_n;

	svl_in_if  in_if ();
	svl_out_if out_if ();

	sorted_value_list #(
		.CAPACITY(LIST_DEPTH)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.in_ch (in_if),
		.out_ch(out_if)
	);

	list_op_t     pending_ops [$];
	list_result_t list_expect [$];
	list_state_t  list_model;
	list_state_t  plan_model;

	int unsigned cycle_count  = 0;
	int unsigned error_count  = 0;
	int unsigned result_count = 0;
	int unsigned n_inserted   = 0;
	int unsigned n_full       = 0;
	int unsigned n_deleted    = 0;
	int unsigned n_missed     = 0;
	int unsigned deepest      = 0;

	bit          op_taken     = 0;
	bit          res_taken    = 0;
	int unsigned op_gap       = 0;
	int unsigned res_stall    = 0;
	int unsigned in_burst     = 0;
	int unsigned out_burst    = 0;

	// Applies one operation to a list copy and returns the result it gives.
	function automatic list_result_t apply_list_op(inout list_state_t s, input func_t fn,
		input logic [ValueW-1:0] v);
		list_result_t r;
		int unsigned  pos;
		int unsigned  k;
		pos = 0;
		if (fn == FN_INSERT) begin
			if (s.count >= LIST_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				while (pos < s.count && v > s.entry[pos])
					pos++;
				for (k = s.count; k > pos; k--)
					s.entry[k] = s.entry[k-1];
				s.entry[pos] = v;
				s.count++;
				r.status = ST_INSERTED;
			end
		end else begin
			while (pos < s.count && s.entry[pos] != v)
				pos++;
			if (pos >= s.count) begin
				r.status = ST_NOT_FOUND;
			end else begin
				for (k = pos; k + 1 < s.count; k++)
					s.entry[k] = s.entry[k+1];
				s.count--;
				r.status = ST_DELETED;
			end
		end
		r.entry_count    = CountW'(s.count);
		r.smallest_value = (s.count > 0) ? s.entry[0] : '0;
		return r;
	endfunction

	// Draws the idle cycles before the next item, with occasional runs of none.
	function automatic int unsigned draw_idle(inout int unsigned burst_left);
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			burst_left = $urandom_range(16, 64);
		return $urandom_range(0, 8);
	endfunction

	// Queues an operation and keeps the planning copy of the list in step.
	task automatic queue_op(input func_t fn, input logic [ValueW-1:0] v);
		list_result_t unused;
		pending_ops.push_back('{fn: fn, value: v});
		unused = apply_list_op(plan_model, fn, v);
	endtask

	// Clock.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Cycle limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: run timed out with %0d results outstanding", $realtime,
				list_expect.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Input side: predict the result of every item that is accepted.
	always @(posedge clk) begin
		list_result_t r;
		if (arst_n && in_if.valid && in_if.ready) begin
			r = apply_list_op(list_model, func_t'(in_if.func), in_if.value);
			list_expect.push_back(r);
			op_taken = 1;
		end
	end

	// Input side: present the next item after its idle gap.
	always @(negedge clk) begin
		list_op_t op;
		if (arst_n && !(in_if.valid && !op_taken)) begin
			op_taken = 0;
			if (op_gap > 0) begin
				op_gap--;
				in_if.valid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				op = pending_ops.pop_front();
				in_if.func  <= op.fn;
				in_if.value <= op.value;
				in_if.valid <= 1'b1;
				op_gap = draw_idle(in_burst);
			end else begin
				in_if.valid <= 1'b0;
			end
		end
	end

	// Output side: compare every accepted result with the oldest prediction.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_if.valid && out_if.ready) begin
			res_taken = 1;
			result_count++;
			if (list_expect.size() == 0) begin
				error_count++;
				$display("%0t: result with nothing expected, got status %0d count %0d smallest %0d",
					$realtime, out_if.status, out_if.entry_count, out_if.smallest_value);
			end else begin
				want = list_expect.pop_front();
				if (out_if.status !== want.status) begin
					error_count++;
					$display("%0t: status mismatch, expected %0d, got %0d", $realtime,
						want.status, out_if.status);
				end
				if (out_if.entry_count !== want.entry_count) begin
					error_count++;
					$display("%0t: entry_count mismatch, expected %0d, got %0d", $realtime,
						want.entry_count, out_if.entry_count);
				end
				if (out_if.smallest_value !== want.smallest_value) begin
					error_count++;
					$display("%0t: smallest_value mismatch, expected %0d, got %0d", $realtime,
						want.smallest_value, out_if.smallest_value);
				end
				case (want.status)
					ST_INSERTED: n_inserted++;
					ST_FULL:     n_full++;
					ST_DELETED:  n_deleted++;
					default:     n_missed++;
				endcase
				if (want.entry_count > deepest)
					deepest = want.entry_count;
			end
		end
	end

	// Output side: stall between results for a drawn number of cycles.
	always @(negedge clk) begin
		if (arst_n) begin
			if (res_taken) begin
				res_taken = 0;
				res_stall = draw_idle(out_burst);
			end
			if (res_stall > 0) begin
				res_stall--;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= 1'b1;
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		func_t             fn;
		logic [ValueW-1:0] v;
		int unsigned       random_ops;
		int unsigned       phase_len;
		bit                filling;

		in_if.valid   = 1'b0;
		in_if.func    = 1'b0;
		in_if.value   = '0;
		out_if.ready  = 1'b0;
		arst_n        = 1'b0;
		list_model.count = 0;
		plan_model.count = 0;

		// Directed part: empty list, extremes, duplicates, filling up and overflow.
		queue_op(FN_DELETE, 8'd5);
		queue_op(FN_INSERT, 8'd128);
		queue_op(FN_INSERT, 8'd0);
		queue_op(FN_INSERT, 8'd255);
		queue_op(FN_INSERT, 8'd128);
		queue_op(FN_DELETE, 8'd128);
		queue_op(FN_DELETE, 8'd9);
		queue_op(FN_DELETE, 8'd0);
		for (int i = 0; i < 8; i++) begin
			queue_op(FN_INSERT, 8'd85 + 8'(i));
			queue_op(FN_INSERT, 8'd170 - 8'(i));
		end
		while (plan_model.count < LIST_DEPTH)
			queue_op(FN_INSERT, 8'd1);
		queue_op(FN_INSERT, 8'd7);
		queue_op(FN_DELETE, 8'd255);
		queue_op(FN_INSERT, 8'd255);

		// Random part: alternating fill and drain phases with some noise.
		random_ops = 0;
		filling    = 1'b0;
		while (random_ops < RANDOM_OPS) begin
			filling   = !filling;
			phase_len = $urandom_range(12, 48);
			repeat (phase_len) begin
				if ($urandom_range(0, 99) < 8) begin
					fn = $urandom_range(0, 1) ? FN_DELETE : FN_INSERT;
					v  = 8'($urandom_range(0, 255));
				end else begin
					fn = ($urandom_range(0, 99) < (filling ? 80 : 20)) ? FN_INSERT : FN_DELETE;
					if (plan_model.count > 0 &&
						$urandom_range(0, 99) < ((fn == FN_DELETE) ? 75 : 35))
						v = plan_model.entry[$urandom_range(0, plan_model.count - 1)];
					else if ($urandom_range(0, 9) == 0)
						v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
					else
						v = 8'($urandom_range(0, 255));
				end
				queue_op(fn, v);
				random_ops++;
			end
		end

		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// Let every item go in and every result come back.
		while (pending_ops.size() != 0 || in_if.valid)
			@(posedge clk);
		while (list_expect.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d results: %0d inserts, %0d refused on a full list, %0d deletes, %0d misses.",
			result_count, n_inserted, n_full, n_deleted, n_missed);
		$display("The list reached %0d of %0d entries; %0d mismatches were seen.",
			deepest, LIST_DEPTH, error_count);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
